// ===== hdl/aesel_pkg.sv =====
// Shared types, constants and character helpers for the accept-encoding selector.
package aesel_pkg;

   localparam int unsigned QUALITY_W = 10;

   localparam logic [QUALITY_W-1:0] FULL_QUALITY = 10'd1000;

   // bit positions in the candidate mask
   localparam int unsigned ALIVE_GZIP = 0;
   localparam int unsigned ALIVE_ZSTD = 1;
   localparam int unsigned ALIVE_STAR = 2;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_Q = 8'h71;
   localparam logic [7:0] CH_UP_Q  = 8'h51;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;

   typedef enum logic [1:0] {
      SEC_CODING = 2'd0,
      SEC_NAME   = 2'd1,
      SEC_VALUE  = 2'd2
   } section_type;

   typedef enum logic [1:0] {
      NAME_EMPTY = 2'd0,
      NAME_Q     = 2'd1,
      NAME_OTHER = 2'd2
   } pname_type;

   typedef enum logic [1:0] {
      CHOICE_NONE = 2'd0,
      CHOICE_GZIP = 2'd1,
      CHOICE_ZSTD = 2'd2
   } choice_type;

   typedef struct packed {
      logic [2:0]           len;       // saturates at 6
      logic                 lead_one;
      logic                 bad;
      logic [QUALITY_W-1:0] value;     // thousandths after a leading '0'
   } qparse_type;

   typedef struct packed {
      section_type          section;
      logic [2:0]           alive;
      logic [2:0]           clen;      // saturates at 7
      logic                 gap;
      pname_type            pname;
      qparse_type           qp;
      logic [QUALITY_W-1:0] entry_q;
      logic                 gz_named;
      logic [QUALITY_W-1:0] gz_q;
      logic [QUALITY_W-1:0] zs_q;
      logic [QUALITY_W-1:0] wc_q;
   } parse_state_type;

   typedef struct packed {
      choice_type           choice;
      logic [QUALITY_W-1:0] gzip_weight;
      logic [QUALITY_W-1:0] zstd_weight;
   } result_type;

   localparam qparse_type QP_EMPTY = '{len: 3'd0, lead_one: 1'b0, bad: 1'b0, value: '0};

   localparam parse_state_type STATE_RESET = '{
      section:  SEC_CODING,
      alive:    3'b111,
      clen:     3'd0,
      gap:      1'b0,
      pname:    NAME_EMPTY,
      qp:       QP_EMPTY,
      entry_q:  FULL_QUALITY,
      gz_named: 1'b0,
      gz_q:     '0,
      zs_q:     '0,
      wc_q:     '0
   };

   function automatic logic [7:0] gzip_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = 8'h67; // g
         2'd1:    c = 8'h7A; // z
         2'd2:    c = 8'h69; // i
         default: c = 8'h70; // p
      endcase
      return c;
   endfunction

   function automatic logic [7:0] zstd_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = 8'h7A; // z
         2'd1:    c = 8'h73; // s
         2'd2:    c = 8'h74; // t
         default: c = 8'h64; // d
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/aesel_if.sv =====
// Valid/ready channel interfaces for header words and selection results.
interface aesel_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       has_byte;
   logic       header_end;

   modport source (output valid, output text_byte, output has_byte, output header_end,
                   input ready);
   modport sink   (input valid, input text_byte, input has_byte, input header_end,
                   output ready);
endinterface

interface aesel_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] choice;
   logic [9:0] gzip_weight;
   logic [9:0] zstd_weight;

   modport source (output valid, output choice, output gzip_weight, output zstd_weight,
                   input ready);
   modport sink   (input valid, input choice, input gzip_weight, input zstd_weight,
                   output ready);
endinterface

// ===== hdl/accept_encoding_selector.sv =====
// Top level: accept-encoding negotiation selector with input and result registers.
//
//   channel | dir | handshake    | word contents
//   --------+-----+--------------+-------------------------------------------
//   req_bus | in  | valid/ready  | text_byte[7:0], has_byte, header_end
//   rsp_bus | out | valid/ready  | choice[1:0], gzip_weight[9:0], zstd_weight[9:0]
//
// One header word per clock is taken while the input register is not stalled; the
// parser state advances once per word, and the header's result is registered.
// Reset (synchronous, active high) empties both registers and restores the
// parser to the start of a header.
// A held result stalls only a word that would produce a new result; other
// words keep flowing past it.
module accept_encoding_selector
   import aesel_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   aesel_req_if.sink   req_bus,
   aesel_rsp_if.source rsp_bus
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_has_ff;
   logic       in_last_ff;

   // parser state
   parse_state_type state_ff, state_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   result_type step_result;
   logic       advance;
   logic       req_take;
   logic       rsp_load;

   // the stored word moves on unless it ends a header while a result still waits
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_bus.ready);
   assign rsp_load = advance && in_last_ff;
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

   aesel_step u_step (
      .cur_state  (state_ff),
      .text_byte  (in_byte_ff),
      .has_byte   (in_has_ff),
      .header_end (in_last_ff),
      .next_state (state_in),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.text_byte;
         in_has_ff  <= req_bus.has_byte;
         in_last_ff <= req_bus.header_end;
      end
      if (rsp_load) rsp_data_ff <= step_result;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.choice      = rsp_data_ff.choice;
   assign rsp_bus.gzip_weight = rsp_data_ff.gzip_weight;
   assign rsp_bus.zstd_weight = rsp_data_ff.zstd_weight;

   // a new result never lands on one that has not been taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !rsp_load)
      else $error("result register overwritten");

   // every header starts from a clean parser
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (state_ff == STATE_RESET))
      else $error("parser not cleared after header end");

   // zstd only wins with a nonzero weight at least that of gzip
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.choice == CHOICE_ZSTD) |->
         (rsp_data_ff.zstd_weight != '0 &&
          rsp_data_ff.zstd_weight >= rsp_data_ff.gzip_weight))
      else $error("zstd chosen without sufficient weight");

   // stored weights stay within full quality
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.gz_q <= FULL_QUALITY && state_ff.zs_q <= FULL_QUALITY &&
       state_ff.wc_q <= FULL_QUALITY && state_ff.entry_q <= FULL_QUALITY))
      else $error("quality out of range");

   // a stalled word is held in the input register
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_last_ff) &&
                                     $stable(in_byte_ff)))
      else $error("stalled word lost");

endmodule

// ===== hdl/aesel_step.sv =====
// Next-state and result logic for one header word.
module aesel_step
   import aesel_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      text_byte,
   input  logic            has_byte,
   input  logic            header_end,
   output parse_state_type next_state,
   output result_type      result
);

   function automatic logic [QUALITY_W-1:0] quality_value(input qparse_type q);
      logic [QUALITY_W-1:0] v;
      if (q.bad || q.len == 3'd0 || q.len == 3'd2 || q.len > 3'd5) v = '0;
      else if (q.lead_one) v = FULL_QUALITY;
      else if (q.len == 3'd1) v = '0;
      else v = q.value;
      return v;
   endfunction

   // close the current parameter; a q applies its weight to the entry
   function automatic parse_state_type part_end(input parse_state_type st);
      parse_state_type r;
      r = st;
      if (st.pname == NAME_Q) begin
         if (st.section == SEC_NAME) r.entry_q = '0;
         else if (st.section == SEC_VALUE) r.entry_q = quality_value(st.qp);
      end
      r.pname = NAME_EMPTY;
      r.qp    = QP_EMPTY;
      r.gap   = 1'b0;
      return r;
   endfunction

   function automatic parse_state_type entry_end(input parse_state_type st);
      parse_state_type r;
      parse_state_type c;
      r = part_end(st);
      c = STATE_RESET;
      if (r.alive[ALIVE_GZIP] && r.clen == 3'd4) begin
         r.gz_named = 1'b1;
         r.gz_q     = r.entry_q;
      end else if (r.alive[ALIVE_ZSTD] && r.clen == 3'd4) begin
         r.zs_q = r.entry_q;
      end else if (r.alive[ALIVE_STAR] && r.clen == 3'd1) begin
         r.wc_q = r.entry_q;
      end
      // keep per-header totals, restart the entry
      c.gz_named = r.gz_named;
      c.gz_q     = r.gz_q;
      c.zs_q     = r.zs_q;
      c.wc_q     = r.wc_q;
      return c;
   endfunction

   function automatic parse_state_type coding_char(input parse_state_type st,
                                                   input logic [7:0] c);
      parse_state_type r;
      logic [7:0]      lc;
      logic [2:0]      keep;
      r    = st;
      lc   = (c >= CH_UP_A && c <= CH_UP_Z) ? (c + 8'd32) : c;
      keep = 3'b000;
      if (!st.gap) begin
         if (st.clen < 3'd4 && lc == gzip_char(st.clen[1:0])) keep[ALIVE_GZIP] = 1'b1;
         if (st.clen < 3'd4 && lc == zstd_char(st.clen[1:0])) keep[ALIVE_ZSTD] = 1'b1;
         if (st.clen == 3'd0 && c == CH_STAR) keep[ALIVE_STAR] = 1'b1;
      end
      r.alive = st.alive & keep;
      if (st.clen < 3'd7) r.clen = st.clen + 3'd1;
      return r;
   endfunction

   function automatic qparse_type value_char(input qparse_type q, input logic gap,
                                             input logic [7:0] c);
      qparse_type           r;
      logic [3:0]           d;
      logic [QUALITY_W-1:0] inc;
      r   = q;
      d   = 4'(c - CH_ZERO);
      inc = '0;
      if (gap) r.bad = 1'b1;
      case (q.len)
         3'd0: begin
            if (c == CH_ONE) r.lead_one = 1'b1;
            else if (c != CH_ZERO) r.bad = 1'b1;
         end
         3'd1: begin
            if (c != CH_DOT) r.bad = 1'b1;
         end
         3'd2, 3'd3, 3'd4: begin
            case (q.len)
               3'd2:    inc = QUALITY_W'(d) * QUALITY_W'(100);
               3'd3:    inc = QUALITY_W'(d) * QUALITY_W'(10);
               default: inc = QUALITY_W'(d);
            endcase
            if (c < CH_ZERO || c > CH_NINE) r.bad = 1'b1;
            else if (q.lead_one) begin
               if (c != CH_ZERO) r.bad = 1'b1;
            end else r.value = q.value + inc;
         end
         default: r.bad = 1'b1;
      endcase
      if (q.len < 3'd6) r.len = q.len + 3'd1;
      return r;
   endfunction

   function automatic parse_state_type take_byte(input parse_state_type st,
                                                 input logic [7:0] c);
      parse_state_type r;
      logic            started;
      r       = st;
      started = 1'b0;
      if (c == CH_COMMA) begin
         r = entry_end(st);
      end else if (c == CH_SEMI) begin
         r = part_end(st);
         r.section = SEC_NAME;
      end else if (c == CH_EQUAL && st.section == SEC_NAME) begin
         r.section = SEC_VALUE;
         r.qp      = QP_EMPTY;
         r.gap     = 1'b0;
      end else if (c == CH_SPACE || c == CH_TAB) begin
         case (st.section)
            SEC_CODING: started = (st.clen != 3'd0);
            SEC_NAME:   started = (st.pname != NAME_EMPTY);
            default:    started = (st.qp.len != 3'd0);
         endcase
         if (started) r.gap = 1'b1;
      end else begin
         case (st.section)
            SEC_CODING: r = coding_char(st, c);
            SEC_NAME: begin
               if (st.pname == NAME_EMPTY)
                  r.pname = (c == CH_LOW_Q || c == CH_UP_Q) ? NAME_Q : NAME_OTHER;
               else
                  r.pname = NAME_OTHER;
            end
            default:    r.qp = value_char(st.qp, st.gap, c);
         endcase
         r.gap = 1'b0;
      end
      return r;
   endfunction

   parse_state_type      after_byte;
   parse_state_type      closed;
   logic [QUALITY_W-1:0] gz;
   logic [QUALITY_W-1:0] zs;

   always_comb begin
      after_byte = has_byte ? take_byte(cur_state, text_byte) : cur_state;
      closed     = entry_end(after_byte);
      gz         = closed.gz_named ? closed.gz_q : closed.wc_q;
      zs         = closed.zs_q;

      result.gzip_weight = gz;
      result.zstd_weight = zs;
      if (zs != '0 && zs >= gz) result.choice = CHOICE_ZSTD;
      else if (gz != '0)        result.choice = CHOICE_GZIP;
      else                      result.choice = CHOICE_NONE;

      next_state = header_end ? STATE_RESET : after_byte;
   end

endmodule
